@@ rtl/gbts_pkg.sv @@
// Gap buffer text store: shared constants, item structs and sequencer states.
// No dependencies; used by gap_buffer_text_store.
package gbts_pkg;

    // Store geometry and field widths
    localparam int CAPACITY  = 4096;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int LEN_BITS  = 13;
    localparam int CHAR_BITS = 16;
    localparam int MAX_READ  = 64;
    localparam int READ_BITS = $clog2(MAX_READ + 1);

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_OFFS = 2'd2;

    typedef struct packed {
        logic [1:0]           op;
        logic [LEN_BITS-1:0]  offset;
        logic [CHAR_BITS-1:0] char_in;
        logic [LEN_BITS-1:0]  count;
        logic                 run_end;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_out;
        logic [1:0]           status;
        logic [LEN_BITS-1:0]  text_len;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_INSERT,
        S_WIDEN,
        S_READ_RD,
        S_READ_WAIT,
        S_EMIT
    } seq_state_t;

endpackage

@@ rtl/gap_buffer_text_store.sv @@
// Gap buffer text store top level: sequencer, gap pointers, store memory, output register.
// Depends on gbts_pkg.
//
//  channel | valid     | stall     | payload            | direction
//  --------+-----------+-----------+--------------------+----------
//  request | req_valid | req_stall | req_item (in_item) | in
//  result  | rsp_valid | rsp_stall | rsp_item (out_item)| out
//
// One item at a time; req_stall is high from acceptance until the item is done.
// Insert: gap move to the offset, one read and one write per character moved, then the
// write; a result only when run_end is set. Remove: gap move, widen, status item.
// Read: a read state and a wait state per character, on the registered memory read.
// Errors and empty reads: status only. Result stalls hold the sequencer where it emits.
// Reset clears pointers and control only; the store needs no clearing pass.
module gap_buffer_text_store (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  gbts_pkg::in_item_t  req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gbts_pkg::out_item_t rsp_item
);

    localparam logic [gbts_pkg::LEN_BITS-1:0] CAP_LEN =
        gbts_pkg::LEN_BITS'(gbts_pkg::CAPACITY);
    localparam logic [gbts_pkg::LEN_BITS-1:0] ONE_LEN  = gbts_pkg::LEN_BITS'(1);
    localparam logic [gbts_pkg::LEN_BITS-1:0] MAX_RD_LEN =
        gbts_pkg::LEN_BITS'(gbts_pkg::MAX_READ);
    localparam logic [gbts_pkg::READ_BITS-1:0] ONE_RD = gbts_pkg::READ_BITS'(1);

    // State registers
    gbts_pkg::seq_state_t                 state_reg, state_next;
    gbts_pkg::in_item_t                   cmd_reg, cmd_next;
    logic [gbts_pkg::LEN_BITS-1:0]        gap_lo_reg, gap_lo_next;
    logic [gbts_pkg::LEN_BITS-1:0]        gap_hi_reg, gap_hi_next;
    logic [gbts_pkg::LEN_BITS-1:0]        text_count_reg, text_count_next;
    logic [gbts_pkg::LEN_BITS-1:0]        num_reg, num_next;
    logic [gbts_pkg::LEN_BITS-1:0]        rd_pos_reg, rd_pos_next;
    logic [gbts_pkg::READ_BITS-1:0]       rd_left_reg, rd_left_next;
    logic [1:0]                           status_reg, status_next;
    logic                                 out_valid_reg;
    gbts_pkg::out_item_t                  out_item_reg;

    // Memory
    logic [gbts_pkg::CHAR_BITS-1:0]       mem [gbts_pkg::CAPACITY];
    logic [gbts_pkg::CHAR_BITS-1:0]       rd_data_reg;
    logic                                 mem_we, mem_re;
    logic [gbts_pkg::ADDR_BITS-1:0]       mem_waddr, mem_raddr;
    logic [gbts_pkg::CHAR_BITS-1:0]       mem_wdata;

    // Datapath helpers
    logic [gbts_pkg::LEN_BITS-1:0]        lo_dec, hi_dec, gap_size, phys_full;
    logic [gbts_pkg::LEN_BITS-1:0]        avail, rd_lim, rd_num;
    logic                                 out_free, out_load;
    gbts_pkg::out_item_t                  out_item_next;

    assign lo_dec    = gap_lo_reg - ONE_LEN;
    assign hi_dec    = gap_hi_reg - ONE_LEN;
    assign gap_size  = gap_hi_reg - gap_lo_reg;
    assign phys_full = (rd_pos_reg < gap_lo_reg) ? rd_pos_reg : rd_pos_reg + gap_size;
    assign avail     = text_count_reg - cmd_reg.offset;
    assign rd_lim    = (cmd_reg.count < MAX_RD_LEN) ? cmd_reg.count : MAX_RD_LEN;
    assign rd_num    = (rd_lim < avail) ? rd_lim : avail;
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != gbts_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbts_pkg::S_IDLE;
            gap_lo_reg     <= '0;
            gap_hi_reg     <= CAP_LEN;
            text_count_reg <= '0;
            rd_left_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            gap_lo_reg     <= gap_lo_next;
            gap_hi_reg     <= gap_hi_next;
            text_count_reg <= text_count_next;
            rd_left_reg    <= rd_left_next;
        end
    end

    // Working payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        num_reg    <= num_next;
        rd_pos_reg <= rd_pos_next;
        status_reg <= status_next;
    end

    // Output register: loads when empty or when the held item leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        gap_lo_next     = gap_lo_reg;
        gap_hi_next     = gap_hi_reg;
        text_count_next = text_count_reg;
        num_next        = num_reg;
        rd_pos_next     = rd_pos_reg;
        rd_left_next    = rd_left_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = gap_lo_reg[gbts_pkg::ADDR_BITS-1:0];
        mem_raddr       = gap_hi_reg[gbts_pkg::ADDR_BITS-1:0];
        mem_wdata       = rd_data_reg;
        out_load        = 1'b0;
        out_item_next   = '{char_out: '0, status: status_reg,
                            text_len: text_count_reg, last: 1'b1};

        case (state_reg)
            gbts_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req_item;
                    state_next = gbts_pkg::S_DECODE;
                end
            end

            // Checks, then pick the path
            gbts_pkg::S_DECODE:
            begin
                status_next = gbts_pkg::ST_OK;
                state_next  = gbts_pkg::S_EMIT;
                case (cmd_reg.op)
                    gbts_pkg::OP_INSERT:
                    begin
                        if (cmd_reg.offset > text_count_reg)
                            status_next = gbts_pkg::ST_BAD_OFFS;
                        else if (text_count_reg >= CAP_LEN)
                            status_next = gbts_pkg::ST_FULL;
                        else
                            state_next = gbts_pkg::S_MOVE_RD;
                    end
                    gbts_pkg::OP_REMOVE:
                    begin
                        if (cmd_reg.offset > text_count_reg)
                            status_next = gbts_pkg::ST_BAD_OFFS;
                        else
                        begin
                            num_next   = (cmd_reg.count < avail) ? cmd_reg.count : avail;
                            state_next = gbts_pkg::S_MOVE_RD;
                        end
                    end
                    gbts_pkg::OP_READ:
                    begin
                        if (cmd_reg.offset > text_count_reg)
                            status_next = gbts_pkg::ST_BAD_OFFS;
                        else if (rd_num != '0)
                        begin
                            rd_left_next = rd_num[gbts_pkg::READ_BITS-1:0];
                            rd_pos_next  = cmd_reg.offset;
                            state_next   = gbts_pkg::S_READ_RD;
                        end
                    end
                    default:
                    begin
                        status_next = gbts_pkg::ST_OK;
                    end
                endcase
            end

            // Gap move: fetch the character that crosses the gap
            gbts_pkg::S_MOVE_RD:
            begin
                if (gap_lo_reg == cmd_reg.offset)
                begin
                    state_next = (cmd_reg.op == gbts_pkg::OP_INSERT) ?
                                 gbts_pkg::S_INSERT : gbts_pkg::S_WIDEN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = (gap_lo_reg > cmd_reg.offset) ?
                                 lo_dec[gbts_pkg::ADDR_BITS-1:0] :
                                 gap_hi_reg[gbts_pkg::ADDR_BITS-1:0];
                    state_next = gbts_pkg::S_MOVE_WR;
                end
            end

            // Gap move: drop it on the far side and step both edges
            gbts_pkg::S_MOVE_WR:
            begin
                mem_we = 1'b1;
                if (gap_lo_reg > cmd_reg.offset)
                begin
                    mem_waddr   = hi_dec[gbts_pkg::ADDR_BITS-1:0];
                    gap_lo_next = lo_dec;
                    gap_hi_next = hi_dec;
                end
                else
                begin
                    mem_waddr   = gap_lo_reg[gbts_pkg::ADDR_BITS-1:0];
                    gap_lo_next = gap_lo_reg + ONE_LEN;
                    gap_hi_next = gap_hi_reg + ONE_LEN;
                end
                state_next = gbts_pkg::S_MOVE_RD;
            end

            gbts_pkg::S_INSERT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = gap_lo_reg[gbts_pkg::ADDR_BITS-1:0];
                mem_wdata       = cmd_reg.char_in;
                gap_lo_next     = gap_lo_reg + ONE_LEN;
                text_count_next = text_count_reg + ONE_LEN;
                status_next     = gbts_pkg::ST_OK;
                state_next      = cmd_reg.run_end ? gbts_pkg::S_EMIT : gbts_pkg::S_IDLE;
            end

            gbts_pkg::S_WIDEN:
            begin
                gap_hi_next     = gap_hi_reg + num_reg;
                text_count_next = text_count_reg - num_reg;
                status_next     = gbts_pkg::ST_OK;
                state_next      = gbts_pkg::S_EMIT;
            end

            // Read walk: map logical to physical round the gap
            gbts_pkg::S_READ_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = phys_full[gbts_pkg::ADDR_BITS-1:0];
                state_next = gbts_pkg::S_READ_WAIT;
            end

            gbts_pkg::S_READ_WAIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_item_next = '{char_out: rd_data_reg, status: gbts_pkg::ST_OK,
                                      text_len: text_count_reg,
                                      last: (rd_left_reg == ONE_RD)};
                    rd_left_next  = rd_left_reg - ONE_RD;
                    rd_pos_next   = rd_pos_reg + ONE_LEN;
                    state_next    = (rd_left_reg == ONE_RD) ?
                                    gbts_pkg::S_IDLE : gbts_pkg::S_READ_RD;
                end
            end

            // Single status item
            gbts_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = gbts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = gbts_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    a_gap_holds_free: assert property (@(posedge clk) disable iff (!rst_n)
        gap_size == (CAP_LEN - text_count_reg))
        else $error("gap size does not match free space");

    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (gap_lo_reg <= gap_hi_reg) && (text_count_reg <= CAP_LEN))
        else $error("gap edges out of order or text too long");

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == gbts_pkg::S_DECODE))
        else $error("accepted item not decoded");

    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == gbts_pkg::S_READ_RD) || (state_reg == gbts_pkg::S_READ_WAIT))
        |-> (rd_left_reg != '0))
        else $error("read walk with nothing left");

endmodule
